// ===== src/sfp_pkg.sv =====
// Shared types and constants for the sync frame parser with 8-bit sum checks.
// Used by sfp_frame_check and sync_frame_parser_sum8; no dependencies.
package sfp_pkg;

  localparam int BODY_DEPTH   = 64;
  localparam int PAYLOAD_MAX  = 32;
  localparam int PREAMBLE_LEN = 3;

  localparam int BODY_AW = $clog2(BODY_DEPTH);
  localparam int LEN_W   = $clog2(BODY_DEPTH + 1);
  localparam int CNT_W   = $clog2(PAYLOAD_MAX + 1);
  localparam int NX_W    = LEN_W + 2;

  localparam logic [7:0] SYNC_A = 8'hAA;
  localparam logic [7:0] SYNC_B = 8'h55;

  // Register indexes of the configuration channel
  localparam logic [7:0] CFG_MIN_LEN   = 8'd0;
  localparam logic [7:0] CFG_MAX_LEN   = 8'd1;
  localparam logic [7:0] CFG_LONG_CMD  = 8'd2;
  localparam logic [7:0] CFG_SHORT_CMD = 8'd3;

  // Event counter slots
  localparam int C_RX   = 0;
  localparam int C_JUNK = 1;
  localparam int C_LEN  = 2;
  localparam int C_FSUM = 3;
  localparam int C_PSUM = 4;
  localparam int C_GOOD = 5;
  localparam int N_CNT  = 6;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_BAD_LEN  = 2'd1,
    ST_BAD_FSUM = 2'd2,
    ST_BAD_PSUM = 2'd3
  } sfp_status_e;

  typedef enum logic [1:0] {
    PH_WAIT_A   = 2'd0,
    PH_WAIT_B   = 2'd1,
    PH_WAIT_LEN = 2'd2,
    PH_BODY     = 2'd3
  } sfp_phase_e;

  typedef enum logic [1:0] {
    CT_RUN   = 2'd0,
    CT_CHECK = 2'd1,
    CT_READ  = 2'd2,
    CT_LOAD  = 2'd3
  } sfp_ctrl_e;

  typedef struct packed {
    sfp_status_e        status;
    logic [CNT_W-1:0]   plen;
  } sfp_check_t;

endpackage

// ===== src/sfp_body_ram.sv =====
// Simple dual-port synchronous RAM holding the frame body bytes.
// One write port, one read port with registered read data; no dependencies.
module sfp_body_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/sfp_frame_check.sv =====
// End-of-body validation: body length, frame sum and payload sum.
// Depends on sfp_pkg; works from running sums kept by the top level.
module sfp_frame_check
  import sfp_pkg::*;
(
  input  logic [LEN_W-1:0] body_len_i,
  input  logic [7:0]       cmd_i,
  input  logic [7:0]       first_pl_i,
  input  logic [7:0]       body_sum_i,
  input  logic [7:0]       last1_i,
  input  logic [7:0]       last2_i,
  input  logic [7:0]       long_cmd_i,
  input  logic [7:0]       short_cmd_i,
  output sfp_check_t       check_o
);

  logic            is_long;
  logic            is_short;
  logic            has_psum;
  logic [NX_W-1:0] nx;
  logic [NX_W-1:0] ovh;
  logic [NX_W-1:0] plen_w;
  logic            bad_len;
  logic [7:0]      psum;
  logic [7:0]      psum_ref;
  logic [7:0]      fsum;

  assign is_long  = (cmd_i == long_cmd_i);
  assign is_short = !is_long && (cmd_i == short_cmd_i);
  assign has_psum = is_long || is_short;

  assign nx     = NX_W'(body_len_i);
  assign ovh    = has_psum ? NX_W'(3) : NX_W'(2);
  assign plen_w = nx - ovh;
  assign bad_len = (nx < ovh) || (nx > ovh + NX_W'(PAYLOAD_MAX)) || (is_short && nx == ovh);

  // Body sum covers everything after the command; drop the trailing check bytes
  assign psum     = has_psum ? (body_sum_i - last1_i - last2_i) : (body_sum_i - last1_i);
  assign psum_ref = is_short ? (psum - first_pl_i) : psum;
  assign fsum     = 8'(SYNC_A + SYNC_B + PREAMBLE_LEN) + 8'(body_len_i) + cmd_i + psum;

  always_comb begin
    check_o.plen = CNT_W'(plen_w);
    priority if (bad_len) begin
      check_o.status = ST_BAD_LEN;
    end else if (fsum != last1_i) begin
      check_o.status = ST_BAD_FSUM;
    end else if (has_psum && psum_ref != last2_i) begin
      check_o.status = ST_BAD_PSUM;
    end else begin
      check_o.status = ST_GOOD;
    end
  end

endmodule

// ===== src/sync_frame_parser_sum8.sv =====
// Top level of the sync frame parser with 8-bit sum checksums.
// Depends on sfp_pkg, sfp_body_ram and sfp_frame_check.
// Usage:
//   The slave stream takes one received byte per transaction (tdata[7:0]).
//   The parser hunts for AA 55, takes a length byte and stores the body in
//   a 64-entry RAM. At body end it checks length, frame sum and payload sum.
//   The master stream returns one transaction per payload byte of a good
//   frame, or one status transaction otherwise (a rejection, or a good frame with no payload); tlast marks the final
//   transaction caused by an input byte, tuser carries the status code.
//   Every result carries snapshots of the six wrapping event counters.
// Flow control:
//   Sync and body bytes are taken one per cycle, also while a result waits;
//   a length byte needs the output register free, and a rejection appears
//   in the cycle after it. After the last body byte the check state also reads
//   the first payload byte; each payload byte then passes through the load
//   state, and each later one through the read state before it; input is held
//   while these states run, and while the receiver stalls.
// Reset clears counters, restores register defaults and restarts the hunt;
// the body RAM needs no clearing. A stalled receiver holds the output
// register and stops payload emission.
module sync_frame_parser_sum8
  import sfp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // Byte input
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  // Result output
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] command_code, [13:8] payload_count, [21:14] payload_byte,
  // [53:22] count_rx_bytes, [85:54] count_junk, [117:86] count_bad_length,
  // [149:118] count_bad_frame_sum, [181:150] count_bad_payload_sum,
  // [213:182] count_good, [215:214] zero
  output logic [215:0] m_axis_tdata,
  output logic         m_axis_tlast,
  output logic [1:0]   m_axis_tuser,   // [1:0] status
  // Configuration writes
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [7:0]   cfg_data_i
);

  // Configuration
  logic [7:0] min_len_q, max_len_q, long_cmd_q, short_cmd_q;

  // Parser state
  sfp_phase_e       phase_q, phase_d;
  sfp_ctrl_e        ctrl_q, ctrl_d;
  logic [LEN_W-1:0] exp_q, exp_d;
  logic [LEN_W-1:0] rcv_q, rcv_d;
  logic [31:0]      cnt_q [N_CNT];
  logic [31:0]      cnt_d [N_CNT];
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] plen_q, plen_d;

  // Running body values
  logic [7:0] cmd_q, first_pl_q, sum_q, last1_q, last2_q;

  // Output register
  logic        out_valid_q;
  sfp_status_e out_status_q, res_status;
  logic [7:0]  out_cmd_q, res_cmd;
  logic [5:0]  out_pcnt_q, res_pcnt;
  logic [7:0]  out_byte_q, res_byte;
  logic        out_last_q, res_last;
  logic [31:0] out_cnt_q [N_CNT];

  logic             in_acc;
  logic             out_free;
  logic             out_load;
  logic             len_ok;
  logic             body_done;
  logic             emit_last;
  logic             chk_emit;
  logic             wr_en;
  logic             rd_en;
  logic [BODY_AW-1:0] rd_addr;
  logic [7:0]       rd_data;
  logic [7:0]       b;
  sfp_check_t       chk;

  assign b        = s_axis_tdata;
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (ctrl_q == CT_RUN) && ((phase_q != PH_WAIT_LEN) || out_free);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  assign len_ok = (b >= min_len_q) && (b <= max_len_q) &&
                  ({1'b0, b} >= 9'(PREAMBLE_LEN + 2)) &&
                  ({1'b0, b} <= 9'(PREAMBLE_LEN + BODY_DEPTH));
  assign body_done = (phase_q == PH_BODY) &&
                     ((NX_W'(rcv_q) + NX_W'(1)) >= NX_W'(exp_q));
  assign emit_last = (idx_q == plen_q);
  assign chk_emit  = (chk.status == ST_GOOD) && (chk.plen != '0);

  sfp_body_ram #(
    .DEPTH(BODY_DEPTH),
    .WIDTH(8)
  ) u_body_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (BODY_AW'(rcv_q)),
    .wdata_i (b),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  sfp_frame_check u_check (
    .body_len_i  (exp_q),
    .cmd_i       (cmd_q),
    .first_pl_i  (first_pl_q),
    .body_sum_i  (sum_q),
    .last1_i     (last1_q),
    .last2_i     (last2_q),
    .long_cmd_i  (long_cmd_q),
    .short_cmd_i (short_cmd_q),
    .check_o     (chk)
  );

  // Control sequencer: next state
  always_comb begin
    ctrl_d = ctrl_q;
    unique case (ctrl_q)
      CT_RUN: begin
        if (in_acc && body_done) begin
          ctrl_d = CT_CHECK;
        end
      end
      CT_CHECK: begin
        if (out_free) begin
          ctrl_d = chk_emit ? CT_LOAD : CT_RUN;
        end
      end
      CT_READ: begin
        if (out_free) begin
          ctrl_d = CT_LOAD;
        end
      end
      CT_LOAD: begin
        ctrl_d = emit_last ? CT_RUN : CT_READ;
      end
      default: ctrl_d = CT_RUN;
    endcase
  end

  // Parser and datapath control
  always_comb begin
    phase_d    = phase_q;
    exp_d      = exp_q;
    rcv_d      = rcv_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    plen_d     = plen_q;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = BODY_AW'(idx_q);
    out_load   = 1'b0;
    res_status = ST_GOOD;
    res_cmd    = cmd_q;
    res_pcnt   = '0;
    res_byte   = '0;
    res_last   = 1'b1;

    if (in_acc) begin
      cnt_d[C_RX] = cnt_q[C_RX] + 32'd1;
      unique case (phase_q)
        PH_WAIT_A: begin
          if (b == SYNC_A) begin
            phase_d = PH_WAIT_B;
          end else begin
            cnt_d[C_JUNK] = cnt_q[C_JUNK] + 32'd1;
          end
        end
        PH_WAIT_B: begin
          if (b == SYNC_B) begin
            phase_d = PH_WAIT_LEN;
          end else begin
            // A repeated AA keeps the hunt armed
            phase_d = (b == SYNC_A) ? PH_WAIT_B : PH_WAIT_A;
            cnt_d[C_JUNK] = cnt_q[C_JUNK] + 32'd1;
          end
        end
        PH_WAIT_LEN: begin
          if (len_ok) begin
            exp_d   = LEN_W'(b - 8'(PREAMBLE_LEN));
            rcv_d   = '0;
            phase_d = PH_BODY;
          end else begin
            cnt_d[C_LEN] = cnt_q[C_LEN] + 32'd1;
            phase_d    = (b == SYNC_A) ? PH_WAIT_B : PH_WAIT_A;
            out_load   = 1'b1;
            res_status = ST_BAD_LEN;
            res_cmd    = '0;
          end
        end
        PH_BODY: begin
          wr_en = 1'b1;
          rcv_d = rcv_q + LEN_W'(1);
          if (body_done) begin
            phase_d = PH_WAIT_A;
          end
        end
        default: phase_d = PH_WAIT_A;
      endcase
    end

    unique case (ctrl_q)
      CT_RUN: begin
      end
      CT_CHECK: begin
        if (out_free) begin
          unique case (chk.status)
            ST_GOOD:     cnt_d[C_GOOD] = cnt_q[C_GOOD] + 32'd1;
            ST_BAD_LEN:  cnt_d[C_LEN]  = cnt_q[C_LEN] + 32'd1;
            ST_BAD_FSUM: cnt_d[C_FSUM] = cnt_q[C_FSUM] + 32'd1;
            ST_BAD_PSUM: cnt_d[C_PSUM] = cnt_q[C_PSUM] + 32'd1;
            default: ;
          endcase
          plen_d = chk.plen;
          if (chk_emit) begin
            // Fetch the first payload byte right away
            rd_en   = 1'b1;
            rd_addr = BODY_AW'(1);
            idx_d   = CNT_W'(1);
          end else begin
            out_load   = 1'b1;
            res_status = chk.status;
          end
        end
      end
      CT_READ: begin
        if (out_free) begin
          rd_en = 1'b1;
        end
      end
      CT_LOAD: begin
        out_load = 1'b1;
        res_pcnt = 6'(plen_q);
        res_byte = rd_data;
        res_last = emit_last;
        idx_d    = idx_q + CNT_W'(1);
      end
      default: ;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q   <= 8'd5;
      max_len_q   <= 8'd67;
      long_cmd_q  <= 8'd194;
      short_cmd_q <= 8'd34;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_MIN_LEN)   min_len_q   <= cfg_data_i;
      if (cfg_index_i == CFG_MAX_LEN)   max_len_q   <= cfg_data_i;
      if (cfg_index_i == CFG_LONG_CMD)  long_cmd_q  <= cfg_data_i;
      if (cfg_index_i == CFG_SHORT_CMD) short_cmd_q <= cfg_data_i;
    end
  end

  // Control state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT_A;
      ctrl_q      <= CT_RUN;
      exp_q       <= '0;
      rcv_q       <= '0;
      idx_q       <= '0;
      plen_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < N_CNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      phase_q <= phase_d;
      ctrl_q  <= ctrl_d;
      exp_q   <= exp_d;
      rcv_q   <= rcv_d;
      idx_q   <= idx_d;
      plen_q  <= plen_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Running body values and output payload
  always_ff @(posedge clk_i) begin
    if (in_acc && phase_q == PH_BODY) begin
      if (rcv_q == '0) begin
        cmd_q <= b;
        sum_q <= '0;
      end else begin
        sum_q <= sum_q + b;
      end
      if (rcv_q == LEN_W'(1)) begin
        first_pl_q <= b;
      end
      last2_q <= last1_q;
      last1_q <= b;
    end
    if (out_load) begin
      out_status_q <= res_status;
      out_cmd_q    <= res_cmd;
      out_pcnt_q   <= res_pcnt;
      out_byte_q   <= res_byte;
      out_last_q   <= res_last;
      out_cnt_q    <= cnt_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {2'b00, out_cnt_q[C_GOOD], out_cnt_q[C_PSUM], out_cnt_q[C_FSUM],
                          out_cnt_q[C_LEN], out_cnt_q[C_JUNK], out_cnt_q[C_RX],
                          out_byte_q, out_pcnt_q, out_cmd_q};

  // Never overwrite a result that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready))
    else $error("output register overwritten while stalled");

  // The output register is free whenever RAM data is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_q == CT_LOAD) |-> !out_valid_q)
    else $error("payload load with output register busy");

  // Payload index stays within the frame's payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_q == CT_LOAD) |-> (idx_q >= CNT_W'(1) && idx_q <= plen_q))
    else $error("payload index out of range");

  // Body fill never reaches the expected count before the frame closes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (rcv_q < exp_q))
    else $error("body count overran expected length");

endmodule

// ===== verif/tb_sync_frame_parser_sum8.sv =====
// Self-checking testbench for sync_frame_parser_sum8: byte stream in, frame results out.
// A scoreboard class predicts each result and checks it field by field.
// Depends on sfp_pkg and the parser RTL only.
module tb_sync_frame_parser_sum8
  import sfp_pkg::*;
();

  localparam int         CYCLE_LIMIT = 200000;
  localparam int         HOLD_CYCLES = 300;
  localparam logic [7:0] CFG_UNUSED  = 8'd7;

  typedef enum int {
    SUM_NONE,
    SUM_SHORT,
    SUM_LONG
  } sum_rule_e;

  typedef struct packed {
    sfp_status_e            status;
    logic [7:0]             cmd;
    logic [5:0]             count;
    logic [7:0]             data;
    logic                   last;
    logic [N_CNT-1:0][31:0] ctr;
  } frame_result_t;

  class parser_scoreboard;
    logic [7:0]    min_len, max_len, long_cmd, short_cmd;
    sfp_phase_e    phase;
    logic [7:0]    body_len, body_cnt;
    logic [7:0]    body [BODY_DEPTH];
    logic [31:0]   ctr [N_CNT];
    frame_result_t results_due [$];
    int            errors;

    function new();
      min_len   = 8'd5;
      max_len   = 8'd67;
      long_cmd  = 8'd194;
      short_cmd = 8'd34;
      phase     = PH_WAIT_A;
      body_len  = '0;
      body_cnt  = '0;
      errors    = 0;
      foreach (ctr[i]) ctr[i] = '0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [7:0] val);
      case (idx)
        CFG_MIN_LEN:   min_len = val;
        CFG_MAX_LEN:   max_len = val;
        CFG_LONG_CMD:  long_cmd = val;
        CFG_SHORT_CMD: short_cmd = val;
        default: ;
      endcase
    endfunction

    function void add_result(sfp_status_e st, logic [7:0] cmd, logic [5:0] cnt,
                             logic [7:0] pb, logic last);
      frame_result_t r;
      r.status = st;
      r.cmd    = cmd;
      r.count  = cnt;
      r.data   = pb;
      r.last   = last;
      for (int i = 0; i < N_CNT; i++) r.ctr[i] = ctr[i];
      results_due.push_back(r);
    endfunction

    // Body complete: validate length, frame sum, payload sum; emit payload or status
    function void close_body();
      logic [7:0] cmd, psum, fsum;
      int         n, overhead, plen;
      sum_rule_e  rule;
      n    = body_cnt;
      cmd  = body[0];
      rule = (cmd == long_cmd) ? SUM_LONG : (cmd == short_cmd) ? SUM_SHORT : SUM_NONE;
      overhead = (rule == SUM_NONE) ? 2 : 3;
      if (n < overhead || n - overhead > PAYLOAD_MAX || (rule == SUM_SHORT && n == overhead)) begin
        ctr[C_LEN]++;
        add_result(ST_BAD_LEN, cmd, '0, '0, 1'b1);
        return;
      end
      plen = n - overhead;
      psum = '0;
      for (int i = 0; i < plen; i++) psum += body[1 + i];
      fsum = SYNC_A + SYNC_B + body_len + 8'(PREAMBLE_LEN) + cmd + psum;
      if (fsum != body[n - 1]) begin
        ctr[C_FSUM]++;
        add_result(ST_BAD_FSUM, cmd, '0, '0, 1'b1);
        return;
      end
      if (rule != SUM_NONE) begin
        if (rule == SUM_SHORT) psum -= body[1];
        if (psum != body[n - 2]) begin
          ctr[C_PSUM]++;
          add_result(ST_BAD_PSUM, cmd, '0, '0, 1'b1);
          return;
        end
      end
      ctr[C_GOOD]++;
      if (plen == 0) begin
        add_result(ST_GOOD, cmd, '0, '0, 1'b1);
        return;
      end
      for (int i = 0; i < plen; i++)
        add_result(ST_GOOD, cmd, 6'(plen), body[1 + i], i + 1 == plen);
    endfunction

    function void take_byte(logic [7:0] b);
      ctr[C_RX]++;
      case (phase)
        PH_WAIT_A: begin
          if (b == SYNC_A) phase = PH_WAIT_B;
          else ctr[C_JUNK]++;
        end
        PH_WAIT_B: begin
          if (b == SYNC_B) begin
            phase = PH_WAIT_LEN;
          end else begin
            phase = (b == SYNC_A) ? PH_WAIT_B : PH_WAIT_A;
            ctr[C_JUNK]++;
          end
        end
        PH_WAIT_LEN: begin
          if (b >= min_len && b <= max_len && int'(b) >= PREAMBLE_LEN + 2 &&
              int'(b) - PREAMBLE_LEN <= BODY_DEPTH) begin
            body_len = b - 8'(PREAMBLE_LEN);
            body_cnt = '0;
            phase    = PH_BODY;
          end else begin
            ctr[C_LEN]++;
            phase = (b == SYNC_A) ? PH_WAIT_B : PH_WAIT_A;
            add_result(ST_BAD_LEN, '0, '0, '0, 1'b1);
          end
        end
        default: begin
          body[body_cnt] = b;
          body_cnt++;
          if (body_cnt >= body_len) begin
            phase = PH_WAIT_A;
            close_body();
          end
        end
      endcase
    endfunction

    function void report(string what, logic [31:0] e, logic [31:0] a);
      errors++;
      if (errors <= 10) $display("mismatch on %s: expected %0h, got %0h", what, e, a);
    endfunction

    function void check_result(logic [1:0] st, logic [215:0] d, logic last);
      frame_result_t e;
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: status %0d data %0h", st, d);
        return;
      end
      e = results_due.pop_front();
      if (st != e.status) report("status", 32'(e.status), 32'(st));
      if (d[7:0] != e.cmd) report("command_code", 32'(e.cmd), 32'(d[7:0]));
      if (d[13:8] != e.count) report("payload_count", 32'(e.count), 32'(d[13:8]));
      if (d[21:14] != e.data) report("payload_byte", 32'(e.data), 32'(d[21:14]));
      if (last != e.last) report("last", 32'(e.last), 32'(last));
      for (int i = 0; i < N_CNT; i++)
        if (d[22 + 32 * i +: 32] != e.ctr[i])
          report($sformatf("counter %0d", i), e.ctr[i], d[22 + 32 * i +: 32]);
      if (d[215:214] != 2'b00) report("tdata pad", 32'd0, 32'(d[215:214]));
    endfunction

    function void close_run();
      if (results_due.size() != 0) begin
        errors++;
        $display("%0d expected results never arrived", results_due.size());
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [215:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic [1:0]   m_axis_tuser;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [7:0]   cfg_index_i;
  logic [7:0]   cfg_data_i;

  parser_scoreboard sb = new();
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  bit hold_req       = 1'b0;
  int hold_left      = 0;
  int cycle_cnt      = 0;

  sync_frame_parser_sum8 uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result sink: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk_i)
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);

  // Entered and left at a falling edge; valid stays high into the next byte
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.take_byte(b);
    @(negedge clk_i);
  endtask

  task automatic put_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic write_regs(input logic [7:0] mn, mx, lc, sc);
    put_reg(CFG_MIN_LEN, mn);
    put_reg(CFG_MAX_LEN, mx);
    put_reg(CFG_LONG_CMD, lc);
    put_reg(CFG_SHORT_CMD, sc);
    put_reg(CFG_UNUSED, 8'($urandom_range(255)));
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Nonzero err values corrupt the matching checksum; len_adj skews the length byte
  task automatic send_frame(input logic [7:0] cmd, input int plen, input bit with_psum,
                            input logic [7:0] fsum_err, input logic [7:0] psum_err,
                            input int len_adj);
    logic [7:0] pay [$];
    logic [7:0] full_sum, pay_sum, len_byte;
    full_sum = '0;
    for (int i = 0; i < plen; i++) begin
      pay.push_back(8'($urandom_range(255)));
      full_sum += pay[i];
    end
    pay_sum = full_sum;
    if (cmd == sb.short_cmd && cmd != sb.long_cmd && plen > 0) pay_sum -= pay[0];
    len_byte = 8'(PREAMBLE_LEN + 2 + plen + int'(with_psum) + len_adj);
    send_byte(SYNC_A);
    send_byte(SYNC_B);
    send_byte(len_byte);
    send_byte(cmd);
    foreach (pay[i]) send_byte(pay[i]);
    if (with_psum) send_byte(pay_sum ^ psum_err);
    send_byte((SYNC_A + SYNC_B + len_byte + cmd + full_sum) ^ fsum_err);
  endtask

  task automatic random_frame();
    logic [7:0] cmd, ferr, perr;
    int         pick, plen, len_adj;
    bit         with_psum;
    pick = $urandom_range(99);
    cmd  = (pick < 35) ? sb.long_cmd : (pick < 70) ? sb.short_cmd : 8'($urandom_range(255));
    pick = $urandom_range(99);
    plen = (pick < 70) ? $urandom_range(6) : (pick < 92) ? $urandom_range(32, 7) : PAYLOAD_MAX + 1;
    with_psum = (cmd == sb.long_cmd) || (cmd == sb.short_cmd);
    if ($urandom_range(19) == 0) with_psum = !with_psum;
    ferr    = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 1)) : 8'h00;
    perr    = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 1)) : 8'h00;
    len_adj = ($urandom_range(11) == 0) ? int'($urandom_range(4)) - 2 : 0;
    if ($urandom_range(7) == 0) send_byte(SYNC_A);
    send_frame(cmd, plen, with_psum, ferr, perr, len_adj);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(3, 1);
    repeat (n) send_byte(($urandom_range(3) == 0) ? SYNC_A : 8'($urandom_range(255)));
  endtask

  // Push the parser back to sync hunting so config changes never hit a frame
  task automatic flush_parser();
    while (sb.phase != PH_WAIT_A) send_byte(8'h00);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic settle();
    while (sb.results_due.size() != 0) @(negedge clk_i);
    repeat (24) @(negedge clk_i);
  endtask

  task automatic random_traffic(input int n_bytes);
    logic [31:0] start;
    start = sb.ctr[C_RX];
    while (sb.ctr[C_RX] - start < n_bytes) begin
      if ($urandom_range(9) < 2) send_noise();
      else random_frame();
    end
    flush_parser();
    settle();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, register defaults, no idling
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h13);
    send_byte(SYNC_A);
    send_byte(SYNC_A);
    send_byte(SYNC_B);
    send_byte(8'd4);              // length too small
    send_byte(SYNC_A);
    send_byte(SYNC_B);
    send_byte(SYNC_A);            // length above max, re-arms on AA
    send_byte(SYNC_B);
    send_byte(8'd0);
    send_frame(8'h10, 0, 1'b0, 8'h00, 8'h00, 0);
    send_frame(8'h5A, 3, 1'b0, 8'h00, 8'h00, 0);
    send_frame(sb.long_cmd, 2, 1'b1, 8'h00, 8'h00, 0);
    send_frame(sb.short_cmd, 3, 1'b1, 8'h00, 8'h00, 0);
    send_frame(sb.short_cmd, 0, 1'b1, 8'h00, 8'h00, 0);
    send_frame(8'h77, 4, 1'b0, 8'h01, 8'h00, 0);
    send_frame(sb.long_cmd, 5, 1'b1, 8'h00, 8'h80, 0);
    send_frame(sb.short_cmd, 2, 1'b1, 8'h00, 8'h01, 0);
    send_frame(sb.long_cmd, 0, 1'b0, 8'h00, 8'h00, 0);
    hold_req = 1'b1;
    send_frame(8'hC3, PAYLOAD_MAX, 1'b0, 8'h00, 8'h00, 0);
    send_byte(SYNC_A);
    send_byte(SYNC_B);
    send_byte(8'hFF);
    flush_parser();
    settle();

    // Length window wide open: lengths past the body store must still be rejected
    write_regs(8'd5, 8'd255, 8'd0, 8'd255);
    src_idle_pct = 52;
    send_byte(SYNC_A);
    send_byte(SYNC_B);
    send_byte(8'd68);
    send_byte(SYNC_A);
    send_byte(SYNC_B);
    send_byte(8'd255);
    random_traffic(10);

    // Both commands equal, narrow window
    write_regs(8'd20, 8'd40, 8'd126, 8'd126);
    src_idle_pct   = 0;
    sink_stall_pct = 52;
    random_traffic(10);

    // Min above max: every length byte rejected
    write_regs(8'd255, 8'd5, 8'd194, 8'd34);
    src_idle_pct   = 32;
    sink_stall_pct = 32;
    random_traffic(10);

    write_regs(8'd5, 8'd67, 8'd255, 8'd0);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    random_traffic(10);

    sb.close_run();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sync_frame_parser_sum8.f =====
src/sfp_pkg.sv
src/sfp_body_ram.sv
src/sfp_frame_check.sv
src/sync_frame_parser_sum8.sv
verif/tb_sync_frame_parser_sum8.sv
